// File: design/ldsolv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsolv_pkg
// Shared widths, result codes and divider handshake types for the linear
// Diophantine equation solver.
// ----------------------------------------------------------------------------
package ldsolv_pkg;

  // Width of the operands actually used from each input field.
  localparam int DATA_WIDTH = 32;
  // Bezout coefficient width, with headroom for intermediate values.
  localparam int COEF_W     = DATA_WIDTH + 2;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_SOL = 2'd1;
  localparam logic [1:0] STATUS_ZERO   = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] rem;
  } div_resp_t;

endpackage

// File: design/ldsolv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsolv channel interfaces
// Valid/ready channels for the equation transaction and the result
// transaction.
// ----------------------------------------------------------------------------
interface ldsolv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] rhs_c;

  modport source (output valid, coef_a, coef_b, rhs_c, input ready);
  modport sink   (input valid, coef_a, coef_b, rhs_c, output ready);
endinterface

interface ldsolv_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] gcd_value;
  logic signed [63:0] sol_x;
  logic signed [63:0] sol_y;
  logic signed [31:0] step_x;
  logic signed [31:0] step_y;
  logic        [1:0]  status;

  modport source (output valid, gcd_value, sol_x, sol_y, step_x, step_y, status,
                  input ready);
  modport sink   (input valid, gcd_value, sol_x, sol_y, step_x, step_y, status,
                  output ready);
endinterface

// File: design/linear_diophantine_solver.sv
`timescale 1ns / 1ps
// Sequence: each Euclid step is an issue state, a wait on the serial divider
// and three multiply and update states; at most about 46 steps, then up to
// three final divisions and three multiply states. Throughput: one
// transaction at a time; the shared divider sets the pace. Reset (synchronous,
// active low) returns the sequencer to idle and drops the output valid.
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// Solves a*x + b*y = c with the extended Euclidean algorithm on a shared
// serial divider and one multiplier.
// ----------------------------------------------------------------------------
module linear_diophantine_solver
  import ldsolv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ldsolv_in_if.sink    in_ch,
  ldsolv_out_if.source out_ch
);

  localparam int DW = DATA_WIDTH;
  localparam int SW = DATA_WIDTH + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EUCL = 4'd1;
  localparam logic [3:0] ST_DIVW = 4'd2;
  localparam logic [3:0] ST_M1   = 4'd3;
  localparam logic [3:0] ST_M2   = 4'd4;
  localparam logic [3:0] ST_M3   = 4'd5;
  localparam logic [3:0] ST_FIN  = 4'd6;
  localparam logic [3:0] ST_FDC  = 4'd7;
  localparam logic [3:0] ST_FDB  = 4'd8;
  localparam logic [3:0] ST_FDA  = 4'd9;
  localparam logic [3:0] ST_MX   = 4'd10;
  localparam logic [3:0] ST_MY   = 4'd11;
  localparam logic [3:0] ST_MW   = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0]               state_r, state_nxt;
  logic signed [SW-1:0]     a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [DW-1:0]            ra_r, ra_nxt, rb_r, rb_nxt, quo_r, quo_nxt;
  logic signed [COEF_W-1:0] p_r, p_nxt, pn_r, pn_nxt, qc_r, qc_nxt, qn_r, qn_nxt;
  logic signed [SW-1:0]     k_r, k_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [2*COEF_W-1:0] prod_r, prod_nxt, x_r, x_nxt;
  logic [1:0]               stat_r, stat_nxt;

  logic                     ov_r, ov_nxt;
  logic [31:0]              o_gcd_r, o_gcd_nxt;
  logic signed [63:0]       o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic signed [31:0]       o_sx_r, o_sx_nxt, o_sy_r, o_sy_nxt;
  logic [1:0]               o_st_r, o_st_nxt;

  logic signed [COEF_W-1:0] mul_a, mul_b;
  logic signed [SW-1:0]     in_a, in_b, in_c;
  logic signed [COEF_W-1:0] quo_s;
  div_req_t                 dreq;
  div_resp_t                dresp;

  function automatic logic [DW-1:0] mag(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] n;
    n = -v;
    return v[SW-1] ? n[DW-1:0] : v[DW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] apply_sign(input logic neg,
                                                       input logic [DW-1:0] m);
    logic signed [SW-1:0] e;
    e = $signed({1'b0, m});
    return neg ? -e : e;
  endfunction

  ldsolv_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .resp (dresp)
  );

  assign in_a  = $signed(in_ch.coef_a[DW-1:0]);
  assign in_b  = $signed(in_ch.coef_b[DW-1:0]);
  assign in_c  = $signed(in_ch.rhs_c[DW-1:0]);
  assign quo_s = $signed({2'b00, quo_r});

  assign in_ch.ready = (state_r == ST_IDLE);

  // Operand selection for the single shared multiplier. The y product is kept
  // in the product register until the result is loaded.
  always_comb begin
    mul_a = p_r;
    mul_b = COEF_W'(k_r);
    unique case (state_r) inside
      ST_M1: begin
        mul_a = quo_s;
        mul_b = pn_r;
      end
      ST_M2: begin
        mul_a = quo_s;
        mul_b = qn_r;
      end
      ST_MY, ST_MW, ST_DONE: begin
        mul_a = qc_r;
        mul_b = COEF_W'(k_r);
      end
      default: begin
        mul_a = p_r;
        mul_b = COEF_W'(k_r);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r;  b_nxt = b_r;  c_nxt = c_r;
    ra_nxt = ra_r;  rb_nxt = rb_r;  quo_nxt = quo_r;
    p_nxt = p_r;  pn_nxt = pn_r;  qc_nxt = qc_r;  qn_nxt = qn_r;
    k_nxt = k_r;  sx_nxt = sx_r;  sy_nxt = sy_r;
    x_nxt = x_r;  stat_nxt = stat_r;
    prod_nxt = mul_a * mul_b;
    dreq.start    = 1'b0;
    dreq.dividend = ra_r;
    dreq.divisor  = rb_r;
    ov_nxt   = ov_r;
    o_gcd_nxt = o_gcd_r;  o_x_nxt = o_x_r;  o_y_nxt = o_y_r;
    o_sx_nxt = o_sx_r;  o_sy_nxt = o_sy_r;  o_st_nxt = o_st_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          a_nxt = in_a;  b_nxt = in_b;  c_nxt = in_c;
          ra_nxt = mag(in_a);  rb_nxt = mag(in_b);
          p_nxt = COEF_W'(1);  pn_nxt = '0;  qc_nxt = '0;  qn_nxt = COEF_W'(1);
          k_nxt = '0;  sx_nxt = '0;  sy_nxt = '0;  x_nxt = '0;  prod_nxt = '0;
          if (in_a == '0 && in_b == '0) begin
            stat_nxt  = STATUS_ZERO;
            ra_nxt    = '0;
            state_nxt = ST_DONE;
          end else begin
            stat_nxt  = STATUS_OK;
            state_nxt = ST_EUCL;
          end
        end
      end
      ST_EUCL: begin
        if (rb_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (dresp.done) begin
          quo_nxt   = dresp.quo;
          ra_nxt    = rb_r;
          rb_nxt    = dresp.rem;
          state_nxt = ST_M1;
        end
      end
      ST_M1: begin
        state_nxt = ST_M2;
      end
      ST_M2: begin
        pn_nxt    = p_r - COEF_W'(prod_r);
        p_nxt     = pn_r;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        qn_nxt    = qc_r - COEF_W'(prod_r);
        qc_nxt    = qn_r;
        state_nxt = ST_EUCL;
      end
      ST_FIN: begin
        if (a_r[SW-1]) p_nxt = -p_r;
        if (b_r[SW-1]) qc_nxt = -qc_r;
        dreq.start    = 1'b1;
        dreq.dividend = mag(c_r);
        dreq.divisor  = ra_r;
        state_nxt     = ST_FDC;
      end
      ST_FDC: begin
        if (dresp.done) begin
          if (dresp.rem != '0) begin
            stat_nxt  = STATUS_NO_SOL;
            state_nxt = ST_DONE;
          end else begin
            k_nxt         = apply_sign(c_r[SW-1], dresp.quo);
            dreq.start    = 1'b1;
            dreq.dividend = mag(b_r);
            dreq.divisor  = ra_r;
            state_nxt     = ST_FDB;
          end
        end
      end
      ST_FDB: begin
        if (dresp.done) begin
          sx_nxt        = apply_sign(b_r[SW-1], dresp.quo);
          dreq.start    = 1'b1;
          dreq.dividend = mag(a_r);
          dreq.divisor  = ra_r;
          state_nxt     = ST_FDA;
        end
      end
      ST_FDA: begin
        if (dresp.done) begin
          sy_nxt    = apply_sign(a_r[SW-1], dresp.quo);
          state_nxt = ST_MX;
        end
      end
      ST_MX: begin
        state_nxt = ST_MY;
      end
      ST_MY: begin
        x_nxt     = prod_r;
        state_nxt = ST_MW;
      end
      ST_MW: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Load the output register once the previous result has been taken.
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          o_gcd_nxt = 32'(ra_r);
          o_st_nxt  = stat_r;
          if (stat_r == STATUS_OK) begin
            o_x_nxt  = 64'(x_r);
            o_y_nxt  = 64'(prod_r);
            o_sx_nxt = 32'(sx_r);
            o_sy_nxt = 32'(sy_r);
          end else begin
            o_x_nxt  = '0;
            o_y_nxt  = '0;
            o_sx_nxt = '0;
            o_sy_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    a_r <= a_nxt;  b_r <= b_nxt;  c_r <= c_nxt;
    ra_r <= ra_nxt;  rb_r <= rb_nxt;  quo_r <= quo_nxt;
    p_r <= p_nxt;  pn_r <= pn_nxt;  qc_r <= qc_nxt;  qn_r <= qn_nxt;
    k_r <= k_nxt;  sx_r <= sx_nxt;  sy_r <= sy_nxt;
    prod_r <= prod_nxt;  x_r <= x_nxt;  stat_r <= stat_nxt;
    o_gcd_r <= o_gcd_nxt;  o_x_r <= o_x_nxt;  o_y_r <= o_y_nxt;
    o_sx_r <= o_sx_nxt;  o_sy_r <= o_sy_nxt;  o_st_r <= o_st_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.gcd_value = o_gcd_r;
  assign out_ch.sol_x     = o_x_r;
  assign out_ch.sol_y     = o_y_r;
  assign out_ch.step_x    = o_sx_r;
  assign out_ch.step_y    = o_sy_r;
  assign out_ch.status    = o_st_r;

endmodule

// File: design/ldsolv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsolv_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ldsolv_div
  import ldsolv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;

  assign shifted = {acc_r, q_r[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      // A borrow out of the trial subtraction means the quotient bit is zero.
      if (!diff[DATA_WIDTH]) begin
        acc_nxt = diff[DATA_WIDTH-1:0];
      end else begin
        acc_nxt = shifted[DATA_WIDTH-1:0];
      end
      q_nxt   = {q_r[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_WIDTH - 1);
      acc_nxt  = '0;
      q_nxt    = req.dividend;
      dvs_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign resp.done = done_r;
  assign resp.quo  = q_r;
  assign resp.rem  = acc_r;

endmodule
